// ===== rtl/b64sd_pkg.sv =====
// b64sd_pkg: shared types, constants and the character classifier for the
// base64 stream decoder. No dependencies.
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned DIGIT_W       = 6;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned ACC_W         = 12;
    localparam int unsigned PHASE_W       = 2;
    localparam int unsigned QUEUE_DEPTH_D = 4;
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'hFFFF;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        K_SKIP  = 2'd0,
        K_DIGIT = 2'd1,
        K_BAD   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [DIGIT_W-1:0]  digit;
        logic                last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    function automatic t_item classify(input logic [CHAR_W-1:0] c, input logic last);
        t_item r;
        r.kind  = K_BAD;
        r.digit = '0;
        r.last  = last;
        if (c >= "A" && c <= "Z") begin
            r.kind  = K_DIGIT;
            r.digit = DIGIT_W'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            r.kind  = K_DIGIT;
            r.digit = DIGIT_W'(c - "a" + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            r.kind  = K_DIGIT;
            r.digit = DIGIT_W'(c - "0" + 8'd52);
        end else if (c == "+") begin
            r.kind  = K_DIGIT;
            r.digit = 6'd62;
        end else if (c == "/") begin
            r.kind  = K_DIGIT;
            r.digit = 6'd63;
        end else if (c == "=" || c == 8'h0D || c == 8'h0A) begin
            r.kind  = K_SKIP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
// base64_stream_decoder: top level of the streaming base64 decoder.
// A character passes the queue, then the output register. Throughput: one character
// per cycle while the queue is not full; the queue and output register absorb stalls.
// Reset (i_rst_n low, synchronous) clears message state, empties the queue
// and sets the capacity register to 65535. Depends on b64sd_pkg and submodules.
`timescale 1ns / 1ps

module base64_stream_decoder
    import b64sd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
    input  logic               s_axis_tlast,   // last_char
    // master side
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // [7:0] data_byte, [23:8] byte_count
    output logic [2:0]         m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic               m_axis_tlast,   // message_end
    // capacity register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    logic [COUNT_W-1:0] r_capacity;
    logic               w_full;
    logic               w_push;
    logic               w_pop;
    t_item              w_item;
    t_q_head            w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    b64sd_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_full   (w_full),
        .o_tready (s_axis_tready),
        .o_push   (w_push),
        .o_item   (w_item)
    );

    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    b64sd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_capacity (r_capacity),
        .i_tready   (m_axis_tready),
        .o_pop      (w_pop),
        .o_tvalid   (m_axis_tvalid),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast)
    );

endmodule

// ===== rtl/b64sd_front.sv =====
// b64sd_front: input request handshake and character classification.
// Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_front
    import b64sd_pkg::*;
(
    input  logic              i_tvalid,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_tready,
    output logic              o_push,
    output t_item             o_item
);

    t_item w_item;

    always_comb begin
        w_item   = classify(i_char, i_last);
        o_tready = !i_full;
        // skipped characters that do not close a message change nothing
        o_push   = i_tvalid && !i_full && (w_item.kind != K_SKIP || i_last);
        o_item   = w_item;
    end

endmodule

// ===== rtl/b64sd_queue.sv =====
// b64sd_queue: small FIFO of classified characters between front and back.
// Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_queue
    import b64sd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_D
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        o_full        = (r_count == CNT_W'(DEPTH));
        o_head.valid  = (r_count != '0);
        o_head.item   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/b64sd_back.sv =====
// b64sd_back: bit accumulator, byte counter, error latch and output register.
// Depends on b64sd_pkg.
`timescale 1ns / 1ps

module b64sd_back
    import b64sd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_head            i_head,
    input  logic [COUNT_W-1:0] i_capacity,
    input  logic               i_tready,
    output logic               o_pop,
    output logic               o_tvalid,
    output logic [23:0]        o_tdata,
    output logic [2:0]         o_tuser,
    output logic               o_tlast
);

    logic [ACC_W-1:0]    r_acc,   n_acc;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [COUNT_W-1:0]  r_cnt,   n_cnt;
    logic [STATUS_W-1:0] r_err,   n_err;

    logic                r_out_valid;
    logic [23:0]         r_tdata;
    logic [2:0]          r_tuser;
    logic                r_tlast;

    logic [ACC_W-1:0]    w_acc_sh;
    logic [7:0]          w_byte;
    logic                w_have_byte;
    logic                w_emit;
    logic [COUNT_W-1:0]  w_count_out;
    logic [STATUS_W-1:0] w_status_out;

    always_comb begin
        o_pop = i_head.valid && (!r_out_valid || i_tready);

        n_acc       = r_acc;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_err       = r_err;
        w_have_byte = 1'b0;
        w_byte      = '0;
        w_acc_sh    = {r_acc[ACC_W-DIGIT_W-1:0], i_head.item.digit};

        if (r_err == ST_OK) begin
            case (i_head.item.kind)
                K_BAD: begin
                    n_err = ST_BAD_CHAR;
                end
                K_DIGIT: begin
                    if (r_phase == '0) begin
                        n_acc   = w_acc_sh;
                        n_phase = 2'd3;
                    end else if (r_cnt >= i_capacity) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        w_have_byte = 1'b1;
                        n_cnt       = r_cnt + 1'b1;
                        n_phase     = r_phase - 1'b1;
                        case (r_phase)
                            2'd3: begin
                                w_byte = w_acc_sh[11:4];
                                n_acc  = {8'd0, w_acc_sh[3:0]};
                            end
                            2'd2: begin
                                w_byte = w_acc_sh[9:2];
                                n_acc  = {10'd0, w_acc_sh[1:0]};
                            end
                            default: begin
                                w_byte = w_acc_sh[7:0];
                                n_acc  = '0;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        w_emit       = w_have_byte || i_head.item.last;
        w_count_out  = (i_head.item.last && n_err != ST_OK) ? '0 : n_cnt;
        w_status_out = i_head.item.last ? n_err : ST_OK;

        if (i_head.item.last) begin
            n_acc   = '0;
            n_phase = '0;
            n_cnt   = '0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc       <= n_acc;
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_err       <= n_err;
                r_out_valid <= w_emit;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_tdata <= {w_count_out, w_byte};
            r_tuser <= {w_status_out, w_have_byte};
            r_tlast <= i_head.item.last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

// ===== test/base64_stream_decoder_test.sv =====
// base64_stream_decoder_test: self-checking bench for the streaming base64 decoder.
// Directed table followed by random messages under several capacity settings.
// Depends on b64sd_pkg and the base64_stream_decoder RTL.
`timescale 1ns / 1ps

module base64_stream_decoder_test;
    import b64sd_pkg::*;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                byte_valid;
        logic                message_end;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  byte_count;
    } t_result;

    typedef enum logic [1:0] {
        ROW_CAP     = 2'd0,
        ROW_CHAR    = 2'd1,
        ROW_CHECKED = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [15:0]  value;
        logic         last;
        t_result      want;
    } t_row;

    localparam t_result NO_RESULT   = '0;
    localparam int      HOLD_CYCLES = 64;
    localparam int      NUM_PHASES  = 7;
    localparam int      PHASE_CHARS = 145;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [7:0] char_code
    logic               s_axis_tlast;   // last_char
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;   // [7:0] data_byte, [23:8] byte_count
    logic [2:0]         m_axis_tuser;   // [0] byte_valid, [2:1] status
    logic               m_axis_tlast;   // message_end
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data;

    base64_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder shadow state
    logic [COUNT_W-1:0]  capacity_q;
    logic [ACC_W-1:0]    acc_bits;
    logic [PHASE_W-1:0]  acc_phase;
    logic [COUNT_W-1:0]  bytes_out;
    logic [STATUS_W-1:0] latched_status;

    t_result pending_results[$];
    t_row    directed_rows[$];
    int      mismatches = 0;
    bit      quiet = 1'b0;
    bit      hold_request = 1'b0;
    bit      pause_pending = 1'b0;
    int      idle_odds = 7;

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("mismatch %s: got %0h expected %0h at %0t", what, seen, wanted, $time);
        mismatches++;
    endtask

    function automatic bit decode_char(input logic [7:0] ch, input bit last,
                                       output t_result r);
        int          sixbits;
        int          nbits;
        int          rest;
        logic [11:0] merged;
        bit          got;
        logic [7:0]  b;
        got = 1'b0;
        b = 8'h00;
        r = NO_RESULT;
        if (latched_status == ST_OK && ch != "=" && ch != 8'h0D && ch != 8'h0A) begin
            sixbits = -1;
            if (ch >= "A" && ch <= "Z") sixbits = ch - "A";
            else if (ch >= "a" && ch <= "z") sixbits = ch - "a" + 26;
            else if (ch >= "0" && ch <= "9") sixbits = ch - "0" + 52;
            else if (ch == "+") sixbits = 62;
            else if (ch == "/") sixbits = 63;
            if (sixbits < 0) begin
                latched_status = ST_BAD_CHAR;
            end else begin
                nbits = acc_phase * 2 + 6;
                merged = {acc_bits[5:0], sixbits[5:0]};
                if (nbits >= 8) begin
                    rest = nbits - 8;
                    if (bytes_out >= capacity_q) begin
                        latched_status = ST_OVERFLOW;
                    end else begin
                        b = 8'(merged >> rest);
                        got = 1'b1;
                        bytes_out = bytes_out + 1'b1;
                        acc_bits = merged & ((12'd1 << rest) - 12'd1);
                        acc_phase = PHASE_W'(rest / 2);
                    end
                end else begin
                    acc_bits = merged;
                    acc_phase = PHASE_W'(nbits / 2);
                end
            end
        end
        if (!last) begin
            if (got) r = '{b, 1'b1, 1'b0, ST_OK, bytes_out};
            return got;
        end
        r = '{b, got, 1'b1, latched_status,
              (latched_status != ST_OK) ? 16'd0 : bytes_out};
        acc_bits = '0;
        acc_phase = '0;
        bytes_out = '0;
        latched_status = ST_OK;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tlast,
                    m_axis_tuser[2:1], m_axis_tdata[23:8]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(got), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.data_byte !== want.data_byte)
                    report_mismatch("data_byte", 32'(got.data_byte),
                                    32'(want.data_byte));
                if (got.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", 32'(got.byte_valid),
                                    32'(want.byte_valid));
                if (got.message_end !== want.message_end)
                    report_mismatch("message_end", 32'(got.message_end),
                                    32'(want.message_end));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.byte_count !== want.byte_count)
                    report_mismatch("byte_count", 32'(got.byte_count),
                                    32'(want.byte_count));
            end
        end
    end

    // result side: random stalls plus long hold-offs on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [7:0] ch, input bit last, input bit checked,
                             input t_result want);
        t_result r;
        bit      has;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        has = decode_char(ch, last, r);
        if (checked) pending_results.push_back(want);
        else if (has) pending_results.push_back(r);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, idle_odds) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        // a skipped or ignored char may still be in flight
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [COUNT_W-1:0] cap);
        wait_drained();
        i_cfg_data  <= cap;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        capacity_q = cap;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [15:0] value, input bit last,
                           input t_result want);
        directed_rows.push_back('{kind, value, last, want});
    endtask

    task automatic send_random_message(inout int sent);
        int         len;
        int         pick;
        int         idx;
        bit         broken;
        logic [7:0] ch;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 20);
        broken = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (broken && pick < 15) begin
                ch = 8'($urandom_range(0, 255));
            end else if (pick < 6) begin
                case ($urandom_range(0, 2))
                    0: ch = "=";
                    1: ch = 8'h0D;
                    default: ch = 8'h0A;
                endcase
            end else begin
                idx = $urandom_range(0, 63);
                if (idx < 26) ch = 8'("A" + idx);
                else if (idx < 52) ch = 8'("a" + idx - 26);
                else if (idx < 62) ch = 8'("0" + idx - 52);
                else if (idx == 62) ch = "+";
                else ch = "/";
            end
            send_char(ch, k == len - 1, 1'b0, NO_RESULT);
            sent++;
            if (pause_pending && k == 0 && len > 1) begin
                pause_pending = 1'b0;
                wait_drained();
            end
        end
    endtask

    initial begin
        int   sent;
        t_row row;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        capacity_q     = CAPACITY_RESET;
        acc_bits       = '0;
        acc_phase      = '0;
        bytes_out      = '0;
        latched_status = ST_OK;

        add_row(ROW_CHAR,    16'("T"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("W"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("F"), 1'b0, NO_RESULT);
        add_row(ROW_CHECKED, 16'("u"), 1'b1, '{8'h6E, 1'b1, 1'b1, ST_OK, 16'd3});
        add_row(ROW_CHAR,    16'("/"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("="), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("/"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'h000D, 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("/"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'h000A, 1'b0, NO_RESULT);
        add_row(ROW_CHECKED, 16'("/"), 1'b1, '{8'hFF, 1'b1, 1'b1, ST_OK, 16'd3});
        add_row(ROW_CHAR,    16'h0000, 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("Q"), 1'b0, NO_RESULT);
        add_row(ROW_CHECKED, 16'("Q"), 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 16'd0});
        add_row(ROW_CHECKED, 16'h00FF, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 16'd0});
        add_row(ROW_CHECKED, 16'("A"), 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 16'd0});
        add_row(ROW_CHECKED, 16'("="), 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK, 16'd0});
        add_row(ROW_CHAR,    16'("+"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("9"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("z"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("0"), 1'b1, NO_RESULT);
        add_row(ROW_CAP,     16'd0, 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("A"), 1'b0, NO_RESULT);
        add_row(ROW_CHECKED, 16'("A"), 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVERFLOW, 16'd0});
        add_row(ROW_CAP,     16'd1, 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("A"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("A"), 1'b0, NO_RESULT);
        add_row(ROW_CHAR,    16'("A"), 1'b0, NO_RESULT);
        add_row(ROW_CHECKED, 16'("A"), 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVERFLOW, 16'd0});
        add_row(ROW_CAP,     16'hFFFF, 1'b0, NO_RESULT);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_CAP) set_capacity(row.value);
            else send_char(row.value[7:0], row.last, row.kind == ROW_CHECKED, row.want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_capacity(COUNT_W'($urandom_range(2, 12)));
                1: set_capacity(16'hFFFF);
                2: set_capacity(16'd0);
                3: set_capacity(16'd1);
                4: set_capacity(COUNT_W'($urandom_range(0, 65535)));
                5: set_capacity(COUNT_W'($urandom_range(0, 40)));
                default: set_capacity(16'hFFFF);
            endcase
            quiet = (phase == 4 || phase == NUM_PHASES - 1);
            idle_odds = (phase == 2) ? 2 : 7;
            if (phase == 3) pause_pending = 1'b1;
            sent = 0;
            while (sent < PHASE_CHARS) begin
                // long hold-off while the sender keeps streaming
                if (phase == 1 && sent > 20 && sent < 40) hold_request = 1'b1;
                send_random_message(sent);
            end
        end

        s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 5000 && pending_results.size() != 0; w++) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), 32'd0);
        repeat (8) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/b64sd_pkg.sv
rtl/b64sd_front.sv
rtl/b64sd_queue.sv
rtl/b64sd_back.sv
rtl/base64_stream_decoder.sv
test/base64_stream_decoder_test.sv
